// File: design/qm_pkg.sv
package qm_pkg;

    // Handshake pair between neighbouring pipeline stages.
    typedef struct packed {
        logic valid;
        logic ready;
    } t_qm_hs;

endpackage

// File: design/qm_if.sv
interface qm_arg_if #(
    parameter int WIDTH = 32
) ();
    logic                    valid;
    logic                    ready;
    logic signed [WIDTH-1:0] arg_fixed;

    modport source (output valid, output arg_fixed, input ready);
    modport sink   (input valid, input arg_fixed, output ready);
endinterface

interface qm_result_if #(
    parameter int WIDTH = 32
) ();
    logic                    valid;
    logic                    ready;
    logic signed [WIDTH-1:0] result_fixed;

    modport source (output valid, output result_fixed, input ready);
    modport sink   (input valid, input result_fixed, output ready);
endinterface

// File: design/qm_step.sv
module qm_step #(
    parameter int INT_BITS  = 8,
    parameter int FRAC_BITS = 24,
    parameter int STEP      = 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  qm_pkg::t_qm_hs           i_flow,
    output qm_pkg::t_qm_hs           o_flow,
    input  logic [INT_BITS-1:0]      i_int,
    input  logic signed [FRAC_BITS+1:0] i_d_lo,
    input  logic signed [FRAC_BITS+1:0] i_d_hi,
    input  logic [FRAC_BITS-1:0]     i_acc,
    output logic [INT_BITS-1:0]      o_int,
    output logic signed [FRAC_BITS+1:0] o_d_lo,
    output logic signed [FRAC_BITS+1:0] o_d_hi,
    output logic [FRAC_BITS-1:0]     o_acc
);

    localparam int BIT_POS = FRAC_BITS - STEP;

    logic                        r_valid;
    logic                        w_ready;
    logic signed [FRAC_BITS+1:0] w_mid;
    logic [INT_BITS-1:0]         r_int;
    logic signed [FRAC_BITS+1:0] r_d_lo;
    logic signed [FRAC_BITS+1:0] r_d_hi;
    logic [FRAC_BITS-1:0]        r_acc;
    logic signed [FRAC_BITS+1:0] n_d_lo;
    logic signed [FRAC_BITS+1:0] n_d_hi;
    logic [FRAC_BITS-1:0]        n_acc;

    // The mediant error is the sum of the two bound errors; its sign is the test.
    assign w_mid   = i_d_lo + i_d_hi;
    assign w_ready = !r_valid || i_flow.ready;

    always_comb begin
        n_d_lo = i_d_lo;
        n_d_hi = i_d_hi;
        n_acc  = i_acc;
        if (w_mid[FRAC_BITS+1]) begin
            n_d_hi = w_mid;
        end else begin
            n_d_lo         = w_mid;
            n_acc[BIT_POS] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_ready) begin
            r_valid <= i_flow.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready && i_flow.valid) begin
            r_int  <= i_int;
            r_d_lo <= n_d_lo;
            r_d_hi <= n_d_hi;
            r_acc  <= n_acc;
        end
    end

    assign o_flow.valid = r_valid;
    assign o_flow.ready = w_ready;
    assign o_int        = r_int;
    assign o_d_lo       = r_d_lo;
    assign o_d_hi       = r_d_hi;
    assign o_acc        = r_acc;

endmodule

// File: design/question_mark_function_eval_top.sv
// Minkowski question-mark function on a signed fixed-point argument with INT_BITS integer
// and FRAC_BITS fraction bits. The integer part of the result is floor(x); the fraction is
// ?(f) truncated to FRAC_BITS bits, found by a Stern-Brocot descent with one step in each
// of FRAC_BITS register stages. Each stage holds the signed errors of the two bounds
// against f, so a step is one add and a sign test. A new argument is taken in every cycle
// while the output is not held back; a stall on the output holds the pipeline without
// losing or repeating a transfer.
module question_mark_function_eval_top #(
    parameter int INT_BITS  = 8,
    parameter int FRAC_BITS = 24
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    qm_arg_if.sink           i_arg,
    qm_result_if.source      o_result
);

    localparam int D_W = FRAC_BITS + 2;

    logic                 w_valid [0:FRAC_BITS];
    logic                 w_ready [1:FRAC_BITS+1];
    logic [INT_BITS-1:0]  w_int   [0:FRAC_BITS];
    logic signed [D_W-1:0] w_d_lo [0:FRAC_BITS];
    logic signed [D_W-1:0] w_d_hi [0:FRAC_BITS];
    logic [FRAC_BITS-1:0] w_acc   [0:FRAC_BITS];
    logic [D_W-1:0]       w_frac_ext;

    assign w_frac_ext = {2'b00, i_arg.arg_fixed[FRAC_BITS-1:0]};

    // Bounds 0/1 and 1/1: the errors are f and f - 1, scaled by 2^FRAC_BITS.
    assign w_valid[0] = i_arg.valid;
    assign w_int[0]   = i_arg.arg_fixed[INT_BITS+FRAC_BITS-1:FRAC_BITS];
    assign w_d_lo[0]  = signed'(w_frac_ext);
    assign w_d_hi[0]  = signed'(w_frac_ext - (D_W'(1) << FRAC_BITS));
    assign w_acc[0]   = '0;

    assign w_ready[FRAC_BITS+1] = o_result.ready;

    for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_step
        qm_pkg::t_qm_hs w_in_flow;
        qm_pkg::t_qm_hs w_out_flow;

        assign w_in_flow.valid = w_valid[k-1];
        assign w_in_flow.ready = w_ready[k+1];
        assign w_valid[k]      = w_out_flow.valid;
        assign w_ready[k]      = w_out_flow.ready;

        qm_step #(
            .INT_BITS  (INT_BITS),
            .FRAC_BITS (FRAC_BITS),
            .STEP      (k)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_flow  (w_in_flow),
            .o_flow  (w_out_flow),
            .i_int   (w_int[k-1]),
            .i_d_lo  (w_d_lo[k-1]),
            .i_d_hi  (w_d_hi[k-1]),
            .i_acc   (w_acc[k-1]),
            .o_int   (w_int[k]),
            .o_d_lo  (w_d_lo[k]),
            .o_d_hi  (w_d_hi[k]),
            .o_acc   (w_acc[k])
        );
    end

    assign i_arg.ready           = w_ready[1];
    assign o_result.valid        = w_valid[FRAC_BITS];
    assign o_result.result_fixed = {w_int[FRAC_BITS], w_acc[FRAC_BITS]};

    // The argument always lies between the two bounds of the last stage.
    a_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (!w_d_lo[FRAC_BITS][D_W-1] && w_d_hi[FRAC_BITS][D_W-1]))
        else $error("bound errors out of order in descent stage");

    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.ready |-> i_arg.ready)
        else $error("input stalled although the output is free");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result.valid)
        else $error("result offered straight after reset");

endmodule

// File: verif/question_mark_function_eval_top_tb.sv
`timescale 1ns / 1ps

module question_mark_function_eval_top_tb;

    localparam int INT_BITS      = 8;
    localparam int FRAC_BITS     = 24;
    localparam int WIDTH         = INT_BITS + FRAC_BITS;
    localparam int RANDOM_ITEMS  = 480;
    localparam int QUIET_ITEMS   = 80;
    localparam int SETTLE_CYCLES = 2 * FRAC_BITS + 8;
    localparam int CYCLE_LIMIT   = 200000;

    typedef struct packed {
        logic [WIDTH-1:0] arg;
        logic [WIDTH-1:0] want;
        logic             known;
    } t_qm_vector;

    localparam int NUM_DIRECTED = 20;
    localparam t_qm_vector DIRECTED [NUM_DIRECTED] = '{
        '{32'h0000_0000, 32'h0000_0000, 1'b1},
        '{32'h0080_0000, 32'h0080_0000, 1'b1},
        '{32'h0100_0000, 32'h0100_0000, 1'b1},
        '{32'h0040_0000, 32'h0020_0000, 1'b1},
        '{32'h00C0_0000, 32'h00E0_0000, 1'b1},
        '{32'h8000_0000, 32'h8000_0000, 1'b1},
        '{32'h7F00_0000, 32'h7F00_0000, 1'b1},
        '{32'hFF80_0000, 32'hFF80_0000, 1'b1},
        '{32'hFF00_0000, 32'hFF00_0000, 1'b1},
        '{32'h7FFF_FFFF, 32'h0000_0000, 1'b0},
        '{32'h80FF_FFFF, 32'h0000_0000, 1'b0},
        '{32'h0000_0001, 32'h0000_0000, 1'b0},
        '{32'h00FF_FFFF, 32'h0000_0000, 1'b0},
        '{32'h0055_5555, 32'h0000_0000, 1'b0},
        '{32'h00AA_AAAB, 32'h0000_0000, 1'b0},
        '{32'hFFFF_FFFF, 32'h0000_0000, 1'b0},
        '{32'h0099_9999, 32'h0000_0000, 1'b0},
        '{32'hA5A5_A5A5, 32'h0000_0000, 1'b0},
        '{32'h5A5A_5A5A, 32'h0000_0000, 1'b0},
        '{32'h0028_F5C3, 32'h0000_0000, 1'b0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    qm_arg_if    #(.WIDTH(WIDTH)) arg_bus ();
    qm_result_if #(.WIDTH(WIDTH)) result_bus ();

    question_mark_function_eval_top #(
        .INT_BITS (INT_BITS),
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_arg   (arg_bus),
        .o_result(result_bus)
    );

    logic [WIDTH-1:0] offered_want [$];
    logic [WIDTH-1:0] result_want [$];
    int mismatches    = 0;
    int cycle_count   = 0;
    int src_idle_pct  = 25;
    int sink_idle_pct = 25;
    int stall_left    = 0;
    bit quiet         = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Floor of the argument kept as the integer part; the fraction is found by a
    // Stern-Brocot descent with exact cross-multiplied comparisons.
    function automatic logic [WIDTH-1:0] qm_value(input logic [WIDTH-1:0] arg);
        logic [63:0]          frac;
        logic [63:0]          lo_num;
        logic [63:0]          lo_den;
        logic [63:0]          hi_num;
        logic [63:0]          hi_den;
        logic [63:0]          med_num;
        logic [63:0]          med_den;
        logic [FRAC_BITS-1:0] weight_sum;
        int                   k;
        frac       = 64'(arg[FRAC_BITS-1:0]);
        lo_num     = 64'd0;
        lo_den     = 64'd1;
        hi_num     = 64'd1;
        hi_den     = 64'd1;
        weight_sum = '0;
        for (k = 1; k <= FRAC_BITS; k++) begin
            med_num = lo_num + hi_num;
            med_den = lo_den + hi_den;
            if (frac * med_den < (med_num << FRAC_BITS)) begin
                hi_num = med_num;
                hi_den = med_den;
            end else begin
                weight_sum[FRAC_BITS-k] = 1'b1;
                lo_num = med_num;
                lo_den = med_den;
            end
        end
        return {arg[WIDTH-1:FRAC_BITS], weight_sum};
    endfunction

    // Fractions are steered towards simple rationals and both ends of the unit interval,
    // where the descent takes its longest runs in one direction.
    function automatic logic [WIDTH-1:0] random_arg();
        logic [WIDTH-1:0] word;
        logic [63:0]      num;
        int               den;
        word = $urandom;
        case ($urandom_range(0, 4))
            0: ;
            1: begin
                den = $urandom_range(2, 40);
                num = (64'($urandom_range(1, den - 1)) << FRAC_BITS) / 64'(den);
                num = num + 64'($urandom_range(0, 4)) - 64'd2;
                word[FRAC_BITS-1:0] = num[FRAC_BITS-1:0];
            end
            2: word[FRAC_BITS-1:0] = FRAC_BITS'($urandom_range(0, 255));
            3: word[FRAC_BITS-1:0] = ~FRAC_BITS'($urandom_range(0, 255));
            default: word[FRAC_BITS-1:0] = word[FRAC_BITS-1:0] & FRAC_BITS'($urandom)
                                           & FRAC_BITS'($urandom);
        endcase
        return word;
    endfunction

    function automatic int pick_idle_pct();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 10;
            default: return 40;
        endcase
    endfunction

    task automatic offer_arg(input logic [WIDTH-1:0] arg, input logic [WIDTH-1:0] want);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 99) < src_idle_pct) begin
            gap = $urandom_range(1, 11);
        end
        if (gap > 0) begin
            arg_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        offered_want.push_back(want);
        arg_bus.arg_fixed <= arg;
        arg_bus.valid     <= 1'b1;
        do @(posedge i_clk); while (!arg_bus.ready);
        @(negedge i_clk);
    endtask

    task automatic wait_for_results();
        arg_bus.valid <= 1'b0;
        do @(negedge i_clk); while (result_want.size() != 0);
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            result_bus.ready <= 1'b0;
        end else if (stall_left > 0) begin
            result_bus.ready <= 1'b0;
            stall_left       <= stall_left - 1;
        end else if (!quiet && $urandom_range(0, 99) < sink_idle_pct) begin
            result_bus.ready <= 1'b0;
            stall_left       <= $urandom_range(0, 10);
        end else begin
            result_bus.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_results
        logic [WIDTH-1:0] want;
        if (i_rst_n) begin
            if (arg_bus.valid && arg_bus.ready && offered_want.size() != 0) begin
                result_want.push_back(offered_want.pop_front());
            end
            if (result_bus.valid && result_bus.ready) begin
                if (result_want.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, result_bus.result_fixed);
                    mismatches++;
                end else begin
                    want = result_want.pop_front();
                    if (result_bus.result_fixed !== want) begin
                        $display("%0t: result_fixed mismatch, expected %h, actual %h",
                                 $time, want, result_bus.result_fixed);
                        mismatches++;
                    end
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin
        int               idx;
        logic [WIDTH-1:0] arg;
        i_rst_n           = 1'b0;
        arg_bus.valid     = 1'b0;
        arg_bus.arg_fixed = '0;
        result_bus.ready  = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (idx = 0; idx < NUM_DIRECTED; idx++) begin
            offer_arg(DIRECTED[idx].arg,
                      DIRECTED[idx].known ? DIRECTED[idx].want : qm_value(DIRECTED[idx].arg));
        end

        for (idx = 0; idx < RANDOM_ITEMS; idx++) begin
            if (idx % 64 == 0) begin
                src_idle_pct  <= pick_idle_pct();
                sink_idle_pct <= pick_idle_pct();
            end
            if (idx == RANDOM_ITEMS / 2) begin
                wait_for_results();
            end
            if (idx == RANDOM_ITEMS - QUIET_ITEMS) begin
                wait_for_results();
                quiet = 1'b1;
            end
            arg = random_arg();
            offer_arg(arg, qm_value(arg));
        end

        arg_bus.valid <= 1'b0;
        while (result_want.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: sim.f
design/qm_pkg.sv
design/qm_if.sv
design/qm_step.sv
design/question_mark_function_eval_top.sv
verif/question_mark_function_eval_top_tb.sv
